// ===== rtl/h4_dfr_pkg.sv =====
// ---------------------------------------------------------------------------
// h4_dfr_pkg
// shared types, sizes and lookup functions of the h4 uart deframer
// ---------------------------------------------------------------------------
`default_nettype none

package h4_dfr_pkg;

    localparam int BLOCK_BYTES  = 64;
    localparam int ACL_BLOCKS   = 8;
    localparam int SYNC_BLOCKS  = 8;
    localparam int EVENT_BLOCKS = 8;
    localparam int NUM_Q        = 3;

    localparam int TOTAL_BLOCKS = ACL_BLOCKS + SYNC_BLOCKS + EVENT_BLOCKS;
    localparam int MAX_AS       = (ACL_BLOCKS > SYNC_BLOCKS) ? ACL_BLOCKS : SYNC_BLOCKS;
    localparam int MAX_BLOCKS   = (MAX_AS > EVENT_BLOCKS) ? MAX_AS : EVENT_BLOCKS;
    localparam int PTR_W        = $clog2(MAX_BLOCKS);
    localparam int OFF_W        = $clog2(BLOCK_BYTES);
    localparam int BIDX_W       = $clog2(TOTAL_BLOCKS);
    localparam int BYTE_AW      = BIDX_W + OFF_W;
    localparam int BYTE_DEPTH   = TOTAL_BLOCKS * BLOCK_BYTES;
    localparam int BL_W         = 7;
    localparam int PLEN_W       = 17;

    localparam logic [7:0] IND_ACL   = 8'h02;
    localparam logic [7:0] IND_SYNC  = 8'h03;
    localparam logic [7:0] IND_EVENT = 8'h04;

    localparam logic [PLEN_W-1:0] HDR_ACL   = PLEN_W'(4);
    localparam logic [PLEN_W-1:0] HDR_SYNC  = PLEN_W'(3);
    localparam logic [PLEN_W-1:0] HDR_EVENT = PLEN_W'(2);

    typedef logic [1:0] t_qsel;
    localparam t_qsel Q_ACL   = 2'd0;
    localparam t_qsel Q_SYNC  = 2'd1;
    localparam t_qsel Q_EVENT = 2'd2;
    localparam t_qsel Q_NONE  = 2'd3;

    typedef enum logic [1:0] {
        REQ_BYTE,
        REQ_POP,
        REQ_CONFIRM,
        REQ_IGNORE
    } t_req;

    typedef enum logic [1:0] {
        KIND_TAKEN,
        KIND_BYTE_OUT,
        KIND_EMPTY,
        KIND_CONFIRMED
    } t_kind;

    typedef enum logic [1:0] {
        PH_WAIT,
        PH_HDR,
        PH_DATA
    } t_phase;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_TERM,
        ST_PLEN,
        ST_STREAM
    } t_state;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] rx_byte;
        logic [1:0] queue_sel;
    } t_in;

    typedef struct packed {
        logic [1:0]      result_kind;
        logic [7:0]      data_byte;
        logic [5:0]      byte_index;
        logic [BL_W-1:0] block_len;
        logic            last_item;
        logic            block_done;
        logic            packet_done;
        logic            overrun;
        logic [2:0]      avail_mask;
    } t_out;

    function automatic logic [PTR_W-1:0] ring_last(input t_qsel q);
        case (q)
            Q_ACL:   ring_last = PTR_W'(ACL_BLOCKS - 1);
            Q_SYNC:  ring_last = PTR_W'(SYNC_BLOCKS - 1);
            default: ring_last = PTR_W'(EVENT_BLOCKS - 1);
        endcase
    endfunction

    function automatic logic [PTR_W-1:0] ptr_next(input t_qsel q, input logic [PTR_W-1:0] p);
        ptr_next = (p == ring_last(q)) ? '0 : p + PTR_W'(1);
    endfunction

    function automatic logic [BIDX_W-1:0] len_base(input t_qsel q);
        case (q)
            Q_ACL:   len_base = '0;
            Q_SYNC:  len_base = BIDX_W'(ACL_BLOCKS);
            default: len_base = BIDX_W'(ACL_BLOCKS + SYNC_BLOCKS);
        endcase
    endfunction

endpackage

`default_nettype wire

// ===== rtl/hci_h4_uart_deframer_top.sv =====
// ---------------------------------------------------------------------------
// hci_h4_uart_deframer_top
// h4 receive deframer: link bytes into three block rings, pop and confirm
// ---------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_stall, i_in_data): one request per beat,
// either a received link byte, a pop of the next block of a queue or a
// confirm that frees the oldest block of a queue.
// Output channel (o_out_valid / i_out_stall, o_out_data): a link byte, a
// confirm, an ignored request or a pop of an empty queue gives one beat; a
// pop gives one beat per stored byte, the last one marked.
// A link byte is handled in the cycle it is accepted, and when its packet ends
// on a full block the zero-length terminating block is written in ST_TERM. Its
// result is registered and seen the cycle after acceptance, or after ST_TERM.
// A pop reads the block length from the length ram (ST_PLEN), then streams
// the byte ram at one byte per cycle while the output is not stalled.
// Requests are handled one at a time.
// After reset all ring pointers are zero and the parser waits for an
// indicator; the rings need no clearing. A stall on the output holds the
// result register and the ram read data, and new requests wait.
// ---------------------------------------------------------------------------
`default_nettype none

module hci_h4_uart_deframer_top (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire h4_dfr_pkg::t_in   i_in_data,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output h4_dfr_pkg::t_out       o_out_data
);

    import h4_dfr_pkg::*;

    t_state            r_state, n_state;
    t_phase            r_phase, n_phase;
    logic [PTR_W-1:0]  r_wptr [NUM_Q];
    logic [PTR_W-1:0]  n_wptr [NUM_Q];
    logic [PTR_W-1:0]  r_rptr [NUM_Q];
    logic [PTR_W-1:0]  n_rptr [NUM_Q];
    logic [PTR_W-1:0]  r_cptr [NUM_Q];
    logic [PTR_W-1:0]  n_cptr [NUM_Q];
    logic [PLEN_W-1:0] r_off, n_off;
    logic [PLEN_W-1:0] r_plen, n_plen;
    t_qsel             r_pq, n_pq;
    logic [7:0]        r_h2, n_h2;
    logic              r_ov, n_ov;
    logic [BIDX_W-1:0] r_blk, n_blk;
    logic [BL_W-1:0]   r_len, n_len;
    logic [BL_W-1:0]   r_iss, n_iss;
    logic [BL_W-1:0]   r_oidx, n_oidx;
    logic              r_rd_pend, n_rd_pend;
    logic              r_out_valid;
    t_out              r_out, n_out;
    logic              out_load;

    logic              out_free;
    logic              accept;

    logic              byte_we;
    logic [BYTE_AW-1:0] byte_waddr;
    logic              byte_re;
    logic [BYTE_AW-1:0] byte_raddr;
    logic [7:0]        byte_rdata;

    logic              len_we;
    logic [BIDX_W-1:0] len_waddr;
    logic [BL_W-1:0]   len_wdata;
    logic              len_re;
    logic [BIDX_W-1:0] len_raddr;
    logic [BL_W-1:0]   len_rdata;

    h4_dfr_ram #(
        .WIDTH (8),
        .DEPTH (BYTE_DEPTH)
    ) u_byte_ram (
        .i_clk     (i_clk),
        .i_wr_en   (byte_we),
        .i_wr_addr (byte_waddr),
        .i_wr_data (i_in_data.rx_byte),
        .i_rd_en   (byte_re),
        .i_rd_addr (byte_raddr),
        .o_rd_data (byte_rdata)
    );

    h4_dfr_ram #(
        .WIDTH (BL_W),
        .DEPTH (TOTAL_BLOCKS)
    ) u_len_ram (
        .i_clk     (i_clk),
        .i_wr_en   (len_we),
        .i_wr_addr (len_waddr),
        .i_wr_data (len_wdata),
        .i_rd_en   (len_re),
        .i_rd_addr (len_raddr),
        .o_rd_data (len_rdata)
    );

    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_in_stall  = !((r_state == ST_IDLE) && out_free);
    assign accept      = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        t_qsel             qd;
        t_qsel             qs;
        logic [PTR_W-1:0]  wd;
        logic [PTR_W-1:0]  w1;
        logic [BIDX_W-1:0] blk_w;
        logic [PLEN_W-1:0] ofs;
        logic [PLEN_W-1:0] new_len;
        logic [PLEN_W-1:0] eff_len;
        logic [BL_W-1:0]   bl;
        logic [BL_W-1:0]   len_val;
        logic              close;
        logic              ov;
        logic              rd_load;
        logic              rd_issue;

        n_state   = r_state;
        n_phase   = r_phase;
        n_wptr    = r_wptr;
        n_rptr    = r_rptr;
        n_cptr    = r_cptr;
        n_off     = r_off;
        n_plen    = r_plen;
        n_pq      = r_pq;
        n_h2      = r_h2;
        n_ov      = r_ov;
        n_blk     = r_blk;
        n_len     = r_len;
        n_iss     = r_iss;
        n_oidx    = r_oidx;
        n_rd_pend = r_rd_pend;
        n_out     = '0;
        out_load  = 1'b0;

        byte_we    = 1'b0;
        byte_waddr = '0;
        byte_re    = 1'b0;
        byte_raddr = {r_blk, r_iss[OFF_W-1:0]};
        len_we     = 1'b0;
        len_waddr  = '0;
        len_wdata  = '0;
        len_re     = 1'b0;
        len_raddr  = '0;

        qd       = (r_pq == Q_NONE) ? Q_EVENT : r_pq;
        qs       = (i_in_data.queue_sel == Q_NONE) ? Q_EVENT : i_in_data.queue_sel;
        wd       = r_wptr[qd];
        w1       = ptr_next(qd, wd);
        blk_w    = len_base(qd) + BIDX_W'(wd);
        ofs      = r_off + PLEN_W'(1);
        new_len  = '0;
        eff_len  = r_plen;
        bl       = '0;
        len_val  = '0;
        close    = 1'b0;
        ov       = 1'b0;
        rd_load  = 1'b0;
        rd_issue = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_out.last_item = 1'b1;
                    case (i_in_data.req_type)
                        REQ_BYTE: begin
                            n_out.result_kind = KIND_TAKEN;
                            out_load = 1'b1;
                            if (r_phase == PH_WAIT) begin
                                n_off = '0;
                                if (i_in_data.rx_byte == IND_ACL) begin
                                    n_pq = Q_ACL;   n_plen = HDR_ACL;   n_phase = PH_HDR;
                                end else if (i_in_data.rx_byte == IND_SYNC) begin
                                    n_pq = Q_SYNC;  n_plen = HDR_SYNC;  n_phase = PH_HDR;
                                end else if (i_in_data.rx_byte == IND_EVENT) begin
                                    n_pq = Q_EVENT; n_plen = HDR_EVENT; n_phase = PH_HDR;
                                end else begin
                                    // unknown indicator dropped
                                    n_off = r_off;
                                end
                            end else begin
                                byte_we    = 1'b1;
                                byte_waddr = {blk_w, r_off[OFF_W-1:0]};
                                n_off      = ofs;
                                // the acl header keeps its length low byte here
                                if (r_off == PLEN_W'(2)) begin
                                    n_h2 = i_in_data.rx_byte;
                                end
                                case (qd)
                                    Q_ACL:   new_len = HDR_ACL + PLEN_W'(r_h2)
                                                     + PLEN_W'({i_in_data.rx_byte, 8'h00});
                                    Q_SYNC:  new_len = HDR_SYNC + PLEN_W'(i_in_data.rx_byte);
                                    default: new_len = HDR_EVENT + PLEN_W'(i_in_data.rx_byte);
                                endcase
                                if (!((ofs < r_plen) && (ofs[OFF_W-1:0] != '0))) begin
                                    close = 1'b1;
                                    if (r_phase == PH_HDR) begin
                                        n_plen  = new_len;
                                        n_phase = PH_DATA;
                                        eff_len = new_len;
                                        close   = (new_len == ofs);
                                    end
                                end
                                if (close) begin
                                    bl = (ofs[OFF_W-1:0] == '0) ? BL_W'(BLOCK_BYTES)
                                                               : BL_W'(ofs[OFF_W-1:0]);
                                    len_we     = 1'b1;
                                    len_waddr  = blk_w;
                                    len_wdata  = bl;
                                    n_wptr[qd] = w1;
                                    ov         = (w1 == r_cptr[qd]);
                                    n_out.block_done = 1'b1;
                                    n_out.overrun    = ov;
                                    if (ofs >= eff_len) begin
                                        n_phase = PH_WAIT;
                                        n_out.packet_done = 1'b1;
                                        // full final block: terminator goes in next cycle
                                        if (bl == BL_W'(BLOCK_BYTES)) begin
                                            out_load = 1'b0;
                                            n_ov     = ov;
                                            n_state  = ST_TERM;
                                        end
                                    end
                                end
                            end
                        end
                        REQ_POP: begin
                            if ((i_in_data.queue_sel == Q_NONE) || (r_rptr[qs] == r_wptr[qs])) begin
                                n_out.result_kind = KIND_EMPTY;
                                out_load = 1'b1;
                            end else begin
                                n_rptr[qs] = ptr_next(qs, r_rptr[qs]);
                                n_blk      = len_base(qs) + BIDX_W'(r_rptr[qs]);
                                len_re     = 1'b1;
                                len_raddr  = n_blk;
                                n_state    = ST_PLEN;
                            end
                        end
                        REQ_CONFIRM: begin
                            if (i_in_data.queue_sel != Q_NONE) begin
                                n_cptr[qs] = ptr_next(qs, r_cptr[qs]);
                            end
                            n_out.result_kind = KIND_CONFIRMED;
                            out_load = 1'b1;
                        end
                        default: begin
                            n_out.result_kind = KIND_TAKEN;
                            out_load = 1'b1;
                        end
                    endcase
                end
            end
            ST_TERM: begin
                // zero-length block after a packet that filled its last block
                len_we     = 1'b1;
                len_waddr  = blk_w;
                len_wdata  = '0;
                n_wptr[qd] = w1;
                n_out.result_kind = KIND_TAKEN;
                n_out.last_item   = 1'b1;
                n_out.block_done  = 1'b1;
                n_out.packet_done = 1'b1;
                n_out.overrun     = r_ov || (w1 == r_cptr[qd]);
                out_load = 1'b1;
                n_state  = ST_IDLE;
            end
            ST_PLEN: begin
                len_val = (len_rdata > BL_W'(BLOCK_BYTES)) ? BL_W'(BLOCK_BYTES) : len_rdata;
                if (len_val == '0) begin
                    if (out_free) begin
                        n_out.result_kind = KIND_BYTE_OUT;
                        n_out.last_item   = 1'b1;
                        out_load = 1'b1;
                        n_state  = ST_IDLE;
                    end
                end else begin
                    n_len   = len_val;
                    n_iss   = '0;
                    n_oidx  = '0;
                    n_state = ST_STREAM;
                end
            end
            ST_STREAM: begin
                rd_load  = r_rd_pend && out_free;
                rd_issue = (r_iss != r_len) && (!r_rd_pend || rd_load);
                byte_re  = rd_issue;
                if (rd_issue) begin
                    n_iss = r_iss + BL_W'(1);
                end
                n_rd_pend = rd_issue || (r_rd_pend && !rd_load);
                if (rd_load) begin
                    n_out.result_kind = KIND_BYTE_OUT;
                    n_out.data_byte   = byte_rdata;
                    n_out.byte_index  = r_oidx[5:0];
                    n_out.block_len   = r_len;
                    n_out.last_item   = (r_oidx + BL_W'(1) == r_len);
                    out_load = 1'b1;
                    n_oidx   = r_oidx + BL_W'(1);
                    if (r_oidx + BL_W'(1) == r_len) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // availability is taken after this cycle's pointer updates
        for (int k = 0; k < NUM_Q; k++) begin
            n_out.avail_mask[k] = (n_rptr[k] != n_wptr[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_phase     <= PH_WAIT;
            r_off       <= '0;
            r_plen      <= '0;
            r_pq        <= Q_ACL;
            r_ov        <= 1'b0;
            r_iss       <= '0;
            r_oidx      <= '0;
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < NUM_Q; k++) begin
                r_wptr[k] <= '0;
                r_rptr[k] <= '0;
                r_cptr[k] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_off       <= n_off;
            r_plen      <= n_plen;
            r_pq        <= n_pq;
            r_ov        <= n_ov;
            r_iss       <= n_iss;
            r_oidx      <= n_oidx;
            r_rd_pend   <= n_rd_pend;
            r_out_valid <= out_load || (r_out_valid && i_out_stall);
            r_wptr      <= n_wptr;
            r_rptr      <= n_rptr;
            r_cptr      <= n_cptr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_h2  <= n_h2;
        r_blk <= n_blk;
        r_len <= n_len;
        if (out_load) begin
            r_out <= n_out;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/h4_dfr_ram.sv =====
// ---------------------------------------------------------------------------
// h4_dfr_ram
// simple dual-port ram, one write and one registered read port
// ---------------------------------------------------------------------------
`default_nettype none

module h4_dfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic             i_rd_en,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        // read data holds while no read is issued
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// ---------------------------------------------------------------------------
// tb_top
// self-checking bench for the h4 deframer: link bytes, pops and confirms are
// driven through the valid/stall request channel; a predictor keeps its own
// copy of the rings, pointers and parser, and every result beat is compared
// field by field with the oldest predicted beat
// ---------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import h4_dfr_pkg::*;

    localparam int    RAND_ITEMS   = 290;
    localparam int    CALM_TAIL    = 40;
    localparam int    DRAIN_CYCLES = 16;
    localparam int    CYCLE_LIMIT  = 2000000;
    localparam int    RING_BYTES   = MAX_BLOCKS * BLOCK_BYTES;

    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic i_in_valid  = 1'b0;
    logic o_in_stall;
    t_in  i_in_data   = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    t_out o_out_data;

    t_in  h4_requests[$];
    t_out h4_results[$];
    int   n_fail     = 0;
    int   n_live     = 0;
    int   n_cycles   = 0;
    int   tx_gap     = 0;
    int   rx_gap     = 0;
    logic tx_idle_on = 1'b1;
    logic rx_idle_on = 1'b1;
    logic calm       = 1'b0;

    // predictor state
    logic [7:0]        ring_mem [3][RING_BYTES];
    logic [BL_W-1:0]   blk_len [3][MAX_BLOCKS];
    logic [PTR_W-1:0]  wr_ptr [3];
    logic [PTR_W-1:0]  rd_ptr [3];
    logic [PTR_W-1:0]  clr_ptr [3];
    logic [PLEN_W-1:0] pkt_ofs;
    logic [PLEN_W-1:0] pkt_len;
    t_qsel             pkt_q;
    t_phase            phase;

    hci_h4_uart_deframer_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always #2 i_clk = ~i_clk;

    function automatic int ring_depth(t_qsel q);
        case (q)
            Q_ACL:   return ACL_BLOCKS;
            Q_SYNC:  return SYNC_BLOCKS;
            default: return EVENT_BLOCKS;
        endcase
    endfunction

    function automatic int hdr_bytes(t_qsel q);
        case (q)
            Q_ACL:   return int'(HDR_ACL);
            Q_SYNC:  return int'(HDR_SYNC);
            default: return int'(HDR_EVENT);
        endcase
    endfunction

    function automatic logic [PTR_W-1:0] ptr_step(t_qsel q, logic [PTR_W-1:0] p);
        return (int'(p) == ring_depth(q) - 1) ? PTR_W'(0) : p + 1'b1;
    endfunction

    function automatic logic [2:0] avail_now();
        logic [2:0] m;
        int         k;
        m = '0;
        for (k = 0; k < NUM_Q; k++) m[k] = (rd_ptr[k] != wr_ptr[k]);
        return m;
    endfunction

    function automatic logic bump_write(t_qsel q);
        wr_ptr[q] = ptr_step(q, wr_ptr[q]);
        return wr_ptr[q] == clr_ptr[q];
    endfunction

    task automatic post_result(t_kind kind, logic [7:0] data, logic [5:0] idx,
                               logic [BL_W-1:0] blen, logic is_last,
                               logic bd, logic pd, logic ov);
        t_out r;
        r.result_kind = kind;
        r.data_byte   = data;
        r.byte_index  = idx;
        r.block_len   = blen;
        r.last_item   = is_last;
        r.block_done  = bd;
        r.packet_done = pd;
        r.overrun     = ov;
        r.avail_mask  = avail_now();
        h4_results.push_back(r);
    endtask

    task automatic parse_link_byte(logic [7:0] v, output logic bd, output logic pd,
                                   output logic ov);
        logic [PTR_W-1:0]  w;
        logic [PLEN_W-1:0] ofs;
        logic [BL_W-1:0]   bl;
        int                base;
        bd = 1'b0;
        pd = 1'b0;
        ov = 1'b0;
        if (phase == PH_WAIT) begin
            case (v)
                IND_ACL: begin
                    pkt_q   = Q_ACL;
                    pkt_len = HDR_ACL;
                end
                IND_SYNC: begin
                    pkt_q   = Q_SYNC;
                    pkt_len = HDR_SYNC;
                end
                IND_EVENT: begin
                    pkt_q   = Q_EVENT;
                    pkt_len = HDR_EVENT;
                end
                default: return;
            endcase
            pkt_ofs = '0;
            phase   = PH_HDR;
            return;
        end
        w    = wr_ptr[pkt_q];
        base = int'(w) * BLOCK_BYTES;
        ring_mem[pkt_q][base + int'(pkt_ofs) % BLOCK_BYTES] = v;
        ofs     = pkt_ofs + 1'b1;
        pkt_ofs = ofs;
        if (ofs < pkt_len && int'(ofs) % BLOCK_BYTES != 0) return;
        if (phase == PH_HDR) begin
            // header complete: the length field gives the packet size
            case (pkt_q)
                Q_ACL: pkt_len = HDR_ACL
                                 + {1'b0, ring_mem[pkt_q][base + 3], ring_mem[pkt_q][base + 2]};
                Q_SYNC:  pkt_len = HDR_SYNC + PLEN_W'(ring_mem[pkt_q][base + 2]);
                default: pkt_len = HDR_EVENT + PLEN_W'(ring_mem[pkt_q][base + 1]);
            endcase
            phase = PH_DATA;
            if (pkt_len != ofs) return;
        end
        bl = (int'(ofs) % BLOCK_BYTES != 0) ? BL_W'(int'(ofs) % BLOCK_BYTES)
                                            : BL_W'(BLOCK_BYTES);
        blk_len[pkt_q][w] = bl;
        ov = bump_write(pkt_q);
        bd = 1'b1;
        if (ofs < pkt_len) return;
        phase = PH_WAIT;
        pd    = 1'b1;
        // packet ending on a full block gets an empty block behind it
        if (bl == BL_W'(BLOCK_BYTES)) begin
            blk_len[pkt_q][wr_ptr[pkt_q]] = '0;
            if (bump_write(pkt_q)) ov = 1'b1;
        end
    endtask

    task automatic deframe_request(t_in req);
        logic             bd;
        logic             pd;
        logic             ov;
        logic             is_empty;
        t_qsel            q;
        logic [PTR_W-1:0] r;
        logic [BL_W-1:0]  n;
        int               i;
        q = req.queue_sel;
        case (req.req_type)
            REQ_BYTE: begin
                parse_link_byte(req.rx_byte, bd, pd, ov);
                post_result(KIND_TAKEN, '0, '0, '0, 1'b1, bd, pd, ov);
            end
            REQ_POP: begin
                is_empty = (q == Q_NONE) ? 1'b1 : (rd_ptr[q] == wr_ptr[q]);
                if (is_empty) begin
                    post_result(KIND_EMPTY, '0, '0, '0, 1'b1, 1'b0, 1'b0, 1'b0);
                end else begin
                    r         = rd_ptr[q];
                    rd_ptr[q] = ptr_step(q, r);
                    n         = blk_len[q][r];
                    if (n == '0) begin
                        post_result(KIND_BYTE_OUT, '0, '0, '0, 1'b1, 1'b0, 1'b0, 1'b0);
                    end else begin
                        for (i = 0; i < int'(n); i++)
                            post_result(KIND_BYTE_OUT, ring_mem[q][int'(r) * BLOCK_BYTES + i],
                                        6'(i), n, i == int'(n) - 1, 1'b0, 1'b0, 1'b0);
                    end
                end
            end
            REQ_CONFIRM: begin
                if (q != Q_NONE) clr_ptr[q] = ptr_step(q, clr_ptr[q]);
                post_result(KIND_CONFIRMED, '0, '0, '0, 1'b1, 1'b0, 1'b0, 1'b0);
            end
            default: begin
                post_result(KIND_TAKEN, '0, '0, '0, 1'b1, 1'b0, 1'b0, 1'b0);
            end
        endcase
    endtask

    task automatic push_item(t_req r, logic [7:0] b, t_qsel q);
        t_in it;
        it.req_type  = r;
        it.rx_byte   = b;
        it.queue_sel = q;
        h4_requests.push_back(it);
        if (r != REQ_IGNORE) n_live++;
    endtask

    task automatic push_link(logic [7:0] b);
        push_item(REQ_BYTE, b, t_qsel'($urandom_range(0, 3)));
    endtask

    // a pop or a confirm, now and then on the unused queue select
    task automatic push_stray();
        t_qsel q;
        q = ($urandom_range(0, 7) == 0) ? Q_NONE : t_qsel'($urandom_range(0, 2));
        push_item(($urandom_range(0, 2) == 0) ? REQ_CONFIRM : REQ_POP, 8'($urandom), q);
    endtask

    // whole packet of total bytes, header included
    task automatic push_packet(t_qsel q, int total, int stray_odds);
        logic [7:0] hb [4];
        logic [7:0] ind;
        int         hdr;
        int         plen;
        int         i;
        for (i = 0; i < 4; i++) hb[i] = 8'($urandom);
        hdr  = hdr_bytes(q);
        plen = total - hdr;
        case (q)
            Q_ACL: begin
                ind   = IND_ACL;
                hb[2] = 8'(plen);
                hb[3] = 8'(plen >> 8);
            end
            Q_SYNC: begin
                ind   = IND_SYNC;
                hb[2] = 8'(plen);
            end
            default: begin
                ind   = IND_EVENT;
                hb[1] = 8'(plen);
            end
        endcase
        push_link(ind);
        for (i = 0; i < total; i++) begin
            if (stray_odds != 0 && $urandom_range(1, stray_odds) == 1) push_stray();
            push_link((i < hdr) ? hb[i] : 8'($urandom));
        end
    endtask

    always @(posedge i_clk) begin : drive_requests
        logic v_nxt;
        t_in  d_nxt;
        v_nxt = 1'b0;
        d_nxt = i_in_data;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) deframe_request(i_in_data);
            if (i_in_valid && o_in_stall) begin
                v_nxt = 1'b1;
            end else if (tx_gap > 0) begin
                tx_gap--;
            end else if (!calm && tx_idle_on && $urandom_range(0, 4) == 0) begin
                tx_gap = $urandom_range(0, 6);
            end else if (h4_requests.size() != 0) begin
                v_nxt = 1'b1;
                d_nxt = h4_requests.pop_front();
            end
            if ($urandom_range(0, 39) == 0) tx_idle_on = !tx_idle_on;
        end
        i_in_valid <= v_nxt;
        i_in_data  <= d_nxt;
        calm       <= (h4_requests.size() < CALM_TAIL);
    end

    task automatic cmp_field(string name, logic [7:0] want, logic [7:0] seen);
        if (seen !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, seen);
            n_fail++;
        end
    endtask

    always @(posedge i_clk) begin : check_results
        t_out want;
        logic s_nxt;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (h4_results.size() == 0) begin
                $display("%0t: unexpected result beat, expected none, actual %h",
                         $time, o_out_data);
                n_fail++;
            end else begin
                want = h4_results.pop_front();
                cmp_field("result_kind", want.result_kind, o_out_data.result_kind);
                cmp_field("data_byte",   want.data_byte,   o_out_data.data_byte);
                cmp_field("byte_index",  want.byte_index,  o_out_data.byte_index);
                cmp_field("block_len",   want.block_len,   o_out_data.block_len);
                cmp_field("last_item",   want.last_item,   o_out_data.last_item);
                cmp_field("block_done",  want.block_done,  o_out_data.block_done);
                cmp_field("packet_done", want.packet_done, o_out_data.packet_done);
                cmp_field("overrun",     want.overrun,     o_out_data.overrun);
                cmp_field("avail_mask",  want.avail_mask,  o_out_data.avail_mask);
            end
        end
        s_nxt = 1'b0;
        if (rx_gap > 0) begin
            rx_gap--;
            s_nxt = 1'b1;
        end else if (!calm && rx_idle_on && $urandom_range(0, 5) == 0) begin
            rx_gap = $urandom_range(0, 6);
            s_nxt  = 1'b1;
        end
        if ($urandom_range(0, 39) == 0) rx_idle_on = !rx_idle_on;
        i_out_stall <= s_nxt;
    end

    always @(posedge i_clk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles == CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        t_qsel      q;
        logic [2:0] full_seen;
        logic [7:0] b;
        int         pick;
        int         shape;
        int         total;
        int         k;
        int         j;

        for (k = 0; k < 3; k++) begin
            for (j = 0; j < RING_BYTES; j++) ring_mem[k][j] = '0;
            for (j = 0; j < MAX_BLOCKS; j++) blk_len[k][j] = '0;
            wr_ptr[k]  = '0;
            rd_ptr[k]  = '0;
            clr_ptr[k] = '0;
        end
        pkt_ofs = '0;
        pkt_len = '0;
        pkt_q   = Q_ACL;
        phase   = PH_WAIT;

        // directed opening
        push_item(REQ_POP, 8'h00, Q_ACL);
        push_item(REQ_CONFIRM, 8'hFF, Q_NONE);
        push_item(REQ_POP, 8'hFF, Q_NONE);
        push_item(REQ_IGNORE, 8'hFF, Q_NONE);
        // clear pointer moved ahead of the write pointer, next event block overruns
        push_item(REQ_CONFIRM, 8'h00, Q_EVENT);
        push_link(8'h00);
        push_link(8'hFF);
        push_packet(Q_EVENT, 2, 0);
        push_packet(Q_SYNC, 4, 0);
        push_packet(Q_ACL, 6, 0);
        push_item(REQ_POP, 8'h5A, Q_ACL);
        push_item(REQ_POP, 8'hA5, Q_SYNC);
        push_item(REQ_POP, 8'h00, Q_EVENT);

        // random part: mostly well-formed packets, with stray requests and noise
        n_live    = 0;
        full_seen = '0;
        while (n_live < RAND_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                q     = t_qsel'($urandom_range(0, 2));
                shape = $urandom_range(0, 15);
                if (shape == 0 || (n_live > 60 && !full_seen[q])) begin
                    total        = BLOCK_BYTES;
                    full_seen[q] = 1'b1;
                end else if (shape == 1) begin
                    total = $urandom_range(BLOCK_BYTES + 1, 2 * BLOCK_BYTES + 12);
                end else begin
                    total = hdr_bytes(q) + $urandom_range(0, 10);
                end
                push_packet(q, total, 12);
            end else if (pick < 78) begin
                push_stray();
            end else if (pick < 92) begin
                b = 8'($urandom);
                if (b >= IND_ACL && b <= IND_EVENT) b = b + 8'd3;
                push_link(b);
            end else begin
                push_item(REQ_IGNORE, 8'($urandom), t_qsel'($urandom_range(0, 3)));
            end
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (h4_requests.size() != 0 || i_in_valid) @(negedge i_clk);
        while (h4_results.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (n_fail == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
